[rtl/core/vasd_pkg.sv]
package vasd_pkg;

    localparam int ENTRIES = 256;
    localparam int SLOT_W  = $clog2(ENTRIES);
    localparam int CNT_W   = SLOT_W + 1;
    localparam int KEY_W   = 256;
    localparam int LEN_W   = 5;
    localparam int RAM_W   = KEY_W + LEN_W;
    localparam int PADDR_W = 3;

    localparam logic [LEN_W-1:0] LEN_MASK = 5'd30;
    localparam logic [15:0] ECNT_MAX = 16'hFFFF;

    localparam logic [1:0] ACT_QUERY = 2'd0;
    localparam logic [1:0] ACT_BEGIN = 2'd1;
    localparam logic [1:0] ACT_BYTE  = 2'd2;
    localparam logic [1:0] ACT_END   = 2'd3;

    localparam logic REG_RATIO   = 1'b0;
    localparam logic REG_MINIMUM = 1'b1;

    localparam logic [3:0] EV_NONE        = 4'd0;
    localparam logic [3:0] EV_RELOAD      = 4'd1;
    localparam logic [3:0] EV_NEED_FULL   = 4'd2;
    localparam logic [3:0] EV_NEED_INCR   = 4'd3;
    localparam logic [3:0] EV_STARTED     = 4'd4;
    localparam logic [3:0] EV_ADDED       = 4'd5;
    localparam logic [3:0] EV_REMOVED     = 4'd6;
    localparam logic [3:0] EV_DUPLICATE   = 4'd7;
    localparam logic [3:0] EV_MISSING     = 4'd8;
    localparam logic [3:0] EV_REPL_START  = 4'd9;
    localparam logic [3:0] EV_REPL_END    = 4'd10;
    localparam logic [3:0] EV_DONE        = 4'd11;
    localparam logic [3:0] EV_CORRUPT     = 4'd12;
    localparam logic [3:0] EV_FULL        = 4'd13;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] epoch;
        logic [31:0] version_from;
        logic [31:0] version_to;
        logic        full_update;
        logic [7:0]  data_byte;
    } in_t;

    typedef struct packed {
        logic [3:0]       event_kind;
        logic [31:0]      stored_version;
        logic [7:0]       slot;
        logic [LEN_W-1:0] key_length;
        logic [15:0]      entry_number;
        logic             last;
    } out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FLAGS,
        PH_KEY
    } phase_t;

    function automatic out_t mk_result(input logic [3:0] kind, input logic [31:0] ver,
                                       input logic [7:0] slot, input logic [LEN_W-1:0] len,
                                       input logic [15:0] num, input logic last);
        out_t r;
        r.event_kind     = kind;
        r.stored_version = ver;
        r.slot           = slot;
        r.key_length     = len;
        r.entry_number   = num;
        r.last           = last;
        return r;
    endfunction

endpackage

[rtl/core/vasd_ram.sv]
module vasd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/vasd_cfg.sv]
module vasd_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vasd_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [7:0]                    cruft_ratio,
    output logic [15:0]                   cruft_minimum
);

    import vasd_pkg::*;

    logic [7:0]  ratio_reg;
    logic [15:0] minimum_reg;
    logic        wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cruft_ratio   = ratio_reg;
    assign cruft_minimum = minimum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_reg   <= 8'd10;
            minimum_reg <= 16'd100;
        end else if (wr_en) begin
            if (paddr[2] == REG_RATIO) begin
                ratio_reg <= pwdata[7:0];
            end else begin
                minimum_reg <= pwdata[15:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_MINIMUM) begin
            prdata = {16'd0, minimum_reg};
        end else begin
            prdata = {24'd0, ratio_reg};
        end
    end

endmodule

[rtl/core/versioned_address_set_diff.sv]
// Keeps a set of up to ENTRIES address keys with an epoch, a version and added and deleted
// counts, and answers sync queries and applies streamed diffs one word at a time. A query,
// a begin or the end of an open diff is registered as a pending result for the emit state;
// ready then stays low until the last result of that word has been moved into the output
// register. A diff byte that does not complete a key gives no result and leaves ready high.
// A diff byte that completes a key starts a search of the key table, which reads one slot per
// cycle from a single-port-read memory, and ready stays low until that result is moved out. A
// full update clears the set at once; no clearing pass is needed.
module versioned_address_set_diff (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  vasd_pkg::in_t                 s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output vasd_pkg::out_t                m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vasd_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    import vasd_pkg::*;

    logic [7:0]  cruft_ratio;
    logic [15:0] cruft_minimum;

    state_t st_reg, st_next;
    phase_t phase_reg, phase_next;
    logic [31:0] sepoch_reg, sepoch_next;
    logic [31:0] sver_reg, sver_next;
    logic [31:0] added_reg, added_next;
    logic [31:0] deleted_reg, deleted_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [KEY_W-1:0] asm_reg, asm_next;
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic add_reg, add_next;
    logic [15:0] ecnt_reg, ecnt_next;
    logic [15:0] ord_reg, ord_next;
    logic [31:0] pepoch_reg, pepoch_next;
    logic [31:0] pver_reg, pver_next;
    logic repl_reg, repl_next;
    logic [CNT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic cmp_en_reg, cmp_en_next;
    logic [SLOT_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic free_found_reg, free_found_next;
    logic [SLOT_W-1:0] free_idx_reg, free_idx_next;
    out_t pend_reg, pend_next;
    logic two_reg, two_next;
    logic m_valid_reg, m_valid_next;
    out_t m_data_reg, m_data_next;

    logic in_acc, out_free, go_emit, go_scan, scan_done, match;
    logic [LEN_W-1:0] pos, flen;
    logic [31:0] active;
    logic [39:0] prod;
    logic [3:0] kind;
    logic [SLOT_W-1:0] issue_idx;

    logic ram_we;
    logic [RAM_W-1:0] ram_rdata;

    vasd_cfg u_cfg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .cruft_ratio   (cruft_ratio),
        .cruft_minimum (cruft_minimum)
    );

    vasd_ram #(
        .WIDTH (RAM_W),
        .DEPTH (ENTRIES)
    ) u_keys (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (free_idx_reg),
        .wdata ({len_reg, asm_reg}),
        .raddr (issue_idx),
        .rdata (ram_rdata)
    );

    assign in_acc    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign issue_idx = scan_cnt_reg[SLOT_W-1:0];
    assign match     = cmp_en_reg && valid_reg[cmp_idx_reg]
                       && (ram_rdata[RAM_W-1:KEY_W] == len_reg)
                       && (ram_rdata[KEY_W-1:0] == asm_reg);
    assign scan_done = cmp_en_reg && (match || (cmp_idx_reg == SLOT_W'(ENTRIES - 1)));
    assign active    = added_reg - deleted_reg;
    assign prod      = active * cruft_ratio;
    assign pos       = len_reg - rem_reg;
    assign flen      = s_data.data_byte[LEN_W-1:0] & LEN_MASK;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE: begin
                if (go_scan) begin
                    st_next = ST_SCAN;
                end else if (go_emit) begin
                    st_next = ST_EMIT;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    st_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free && !two_reg) begin
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = (st_reg == ST_IDLE);
        ram_we  = (st_reg == ST_SCAN) && scan_done && !match && add_reg && free_found_reg;
    end

    always_comb begin
        phase_next      = phase_reg;
        sepoch_next     = sepoch_reg;
        sver_next       = sver_reg;
        added_next      = added_reg;
        deleted_next    = deleted_reg;
        valid_next      = valid_reg;
        asm_next        = asm_reg;
        rem_next        = rem_reg;
        len_next        = len_reg;
        add_next        = add_reg;
        ecnt_next       = ecnt_reg;
        ord_next        = ord_reg;
        pepoch_next     = pepoch_reg;
        pver_next       = pver_reg;
        repl_next       = repl_reg;
        scan_cnt_next   = scan_cnt_reg;
        cmp_en_next     = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        pend_next       = pend_reg;
        two_next        = two_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        go_emit         = 1'b0;
        go_scan         = 1'b0;
        kind            = EV_NONE;

        if ((st_reg == ST_IDLE) && in_acc) begin
            case (s_data.action)
                ACT_QUERY: begin
                    if (s_data.epoch == sepoch_reg && s_data.version_from == sver_reg) begin
                        kind = EV_NONE;
                    end else if (prod < {8'd0, deleted_reg}
                                 && deleted_reg > {16'd0, cruft_minimum}) begin
                        kind = EV_RELOAD;
                    end else if (s_data.epoch != sepoch_reg) begin
                        kind = EV_NEED_FULL;
                    end else begin
                        kind = EV_NEED_INCR;
                    end
                    pend_next = mk_result(kind, sver_reg, 8'd0, '0, 16'd0, 1'b1);
                    go_emit   = 1'b1;
                end
                ACT_BEGIN: begin
                    phase_next = PH_IDLE;
                    rem_next   = '0;
                    if (!s_data.full_update && s_data.epoch != sepoch_reg) begin
                        kind = EV_NEED_FULL;
                    end else if (!s_data.full_update && s_data.version_from != sver_reg) begin
                        kind = EV_NEED_INCR;
                    end else begin
                        pepoch_next = s_data.epoch;
                        pver_next   = s_data.version_to;
                        ecnt_next   = 16'd0;
                        phase_next  = PH_FLAGS;
                        if (s_data.full_update && added_reg != deleted_reg) begin
                            deleted_next = added_reg;
                            valid_next   = '0;
                            repl_next    = 1'b1;
                            kind         = EV_REPL_START;
                        end else begin
                            kind = EV_STARTED;
                        end
                    end
                    pend_next = mk_result(kind, sver_reg, 8'd0, '0, 16'd0, 1'b1);
                    go_emit   = 1'b1;
                end
                ACT_BYTE: begin
                    if (phase_reg == PH_FLAGS) begin
                        len_next = flen;
                        add_next = s_data.data_byte[0];
                        asm_next = '0;
                        rem_next = flen;
                        if (flen == '0) begin
                            go_scan = 1'b1;
                        end else begin
                            phase_next = PH_KEY;
                        end
                    end else if (phase_reg == PH_KEY) begin
                        asm_next[{pos, 3'b000} +: 8] = s_data.data_byte;
                        rem_next = rem_reg - 1'b1;
                        if (rem_reg == LEN_W'(1)) begin
                            go_scan = 1'b1;
                        end
                    end
                    if (go_scan) begin
                        ord_next = ecnt_reg;
                        if (ecnt_reg != ECNT_MAX) begin
                            ecnt_next = ecnt_reg + 1'b1;
                        end
                        phase_next      = PH_FLAGS;
                        scan_cnt_next   = '0;
                        free_found_next = 1'b0;
                    end
                end
                ACT_END: begin
                    if (phase_reg == PH_KEY) begin
                        pend_next  = mk_result(EV_CORRUPT, sver_reg, 8'd0, '0, ecnt_reg, 1'b1);
                        repl_next  = 1'b0;
                        phase_next = PH_IDLE;
                        rem_next   = '0;
                        go_emit    = 1'b1;
                    end else if (phase_reg == PH_FLAGS) begin
                        sepoch_next = pepoch_reg;
                        sver_next   = pver_reg;
                        if (repl_reg) begin
                            pend_next = mk_result(EV_REPL_END, pver_reg, 8'd0, '0, 16'd0, 1'b0);
                            two_next  = 1'b1;
                        end else begin
                            pend_next = mk_result(EV_DONE, pver_reg, 8'd0, '0, ecnt_reg, 1'b1);
                        end
                        repl_next  = 1'b0;
                        phase_next = PH_IDLE;
                        go_emit    = 1'b1;
                    end
                end
                default: begin
                    go_emit = 1'b0;
                end
            endcase
        end

        if (st_reg == ST_SCAN) begin
            if (scan_cnt_reg < CNT_W'(ENTRIES)) begin
                cmp_en_next   = 1'b1;
                cmp_idx_next  = issue_idx;
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (!valid_reg[issue_idx] && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_idx_next   = issue_idx;
                end
            end
            if (scan_done) begin
                cmp_en_next = 1'b0;
                if (add_reg) begin
                    if (match) begin
                        pend_next = mk_result(EV_DUPLICATE, sver_reg, 8'(cmp_idx_reg),
                                              len_reg, ord_reg, 1'b1);
                    end else if (!free_found_reg) begin
                        pend_next = mk_result(EV_FULL, sver_reg, 8'd0, len_reg, ord_reg, 1'b1);
                    end else begin
                        valid_next[free_idx_reg] = 1'b1;
                        added_next = added_reg + 1'b1;
                        pend_next  = mk_result(EV_ADDED, sver_reg, 8'(free_idx_reg),
                                               len_reg, ord_reg, 1'b1);
                    end
                end else begin
                    if (match) begin
                        valid_next[cmp_idx_reg] = 1'b0;
                        deleted_next = deleted_reg + 1'b1;
                        pend_next    = mk_result(EV_REMOVED, sver_reg, 8'(cmp_idx_reg),
                                                 len_reg, ord_reg, 1'b1);
                    end else begin
                        pend_next = mk_result(EV_MISSING, sver_reg, 8'd0, len_reg, ord_reg, 1'b1);
                    end
                end
            end
        end

        if ((st_reg == ST_EMIT) && out_free) begin
            m_valid_next = 1'b1;
            m_data_next  = pend_reg;
            if (two_reg) begin
                pend_next = mk_result(EV_DONE, sver_reg, 8'd0, '0, ecnt_reg, 1'b1);
                two_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg         <= ST_IDLE;
            phase_reg      <= PH_IDLE;
            sepoch_reg     <= '0;
            sver_reg       <= '0;
            added_reg      <= '0;
            deleted_reg    <= '0;
            valid_reg      <= '0;
            asm_reg        <= '0;
            rem_reg        <= '0;
            len_reg        <= '0;
            add_reg        <= 1'b0;
            ecnt_reg       <= '0;
            pepoch_reg     <= '0;
            pver_reg       <= '0;
            repl_reg       <= 1'b0;
            scan_cnt_reg   <= '0;
            cmp_en_reg     <= 1'b0;
            free_found_reg <= 1'b0;
            two_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            st_reg         <= st_next;
            phase_reg      <= phase_next;
            sepoch_reg     <= sepoch_next;
            sver_reg       <= sver_next;
            added_reg      <= added_next;
            deleted_reg    <= deleted_next;
            valid_reg      <= valid_next;
            asm_reg        <= asm_next;
            rem_reg        <= rem_next;
            len_reg        <= len_next;
            add_reg        <= add_next;
            ecnt_reg       <= ecnt_next;
            pepoch_reg     <= pepoch_next;
            pver_reg       <= pver_next;
            repl_reg       <= repl_next;
            scan_cnt_reg   <= scan_cnt_next;
            cmp_en_reg     <= cmp_en_next;
            free_found_reg <= free_found_next;
            two_reg        <= two_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ord_reg      <= ord_next;
        cmp_idx_reg  <= cmp_idx_next;
        free_idx_reg <= free_idx_next;
        pend_reg     <= pend_next;
        m_data_reg   <= m_data_next;
    end

    // The number of occupied slots always equals the added count less the deleted count.
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        32'($countones(valid_reg)) == (added_reg - deleted_reg))
        else $error("occupied slots disagree with the running counts");

    a_query_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_data.action == ACT_QUERY) |=> (st_reg == ST_EMIT))
        else $error("query word did not produce a result");

    a_second_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        two_reg |-> (st_reg == ST_EMIT))
        else $error("second result pending outside the emit state");

endmodule
